>>> hdl/hhcs_pkg.sv
// Shared types and codes for the heat / hold / cool sequencer.
// Used by every module of the block and by its checker.
`timescale 1ns / 1ps
package hhcs_pkg;

  // Operating mode
  typedef enum logic [1:0] {
    MD_IDLE   = 2'd0,
    MD_AUTO   = 2'd1,
    MD_MANUAL = 2'd2,
    MD_EMERG  = 2'd3
  } mode_t;

  // Process state
  typedef enum logic [2:0] {
    PS_IDLE   = 3'd0,
    PS_HEAT   = 3'd1,
    PS_HOLD   = 3'd2,
    PS_COOL   = 3'd3,
    PS_DONE   = 3'd4,
    PS_MANUAL = 3'd5,
    PS_FAULT  = 3'd6,
    PS_EMERG  = 3'd7
  } pstate_t;

  // Fault code
  typedef enum logic [1:0] {
    FLT_NONE   = 2'd0,
    FLT_SENSOR = 2'd1,
    FLT_OVER   = 2'd2,
    FLT_EMERG  = 2'd3
  } fault_t;

  // Command status
  typedef enum logic [1:0] {
    CST_NONE     = 2'd0,
    CST_EXECUTED = 2'd1,
    CST_REJECTED = 2'd2
  } cmd_status_t;

  // Action codes carried in the input word's tuser
  localparam logic [3:0] ACT_TICK        = 4'd0;
  localparam logic [3:0] ACT_AUTO_START  = 4'd1;
  localparam logic [3:0] ACT_STOP        = 4'd2;
  localparam logic [3:0] ACT_MANUAL      = 4'd3;
  localparam logic [3:0] ACT_EMERG_STOP  = 4'd4;
  localparam logic [3:0] ACT_CLEAR_EMERG = 4'd5;
  localparam logic [3:0] ACT_RESET       = 4'd6;
  localparam logic [3:0] ACT_HEATER      = 4'd7;
  localparam logic [3:0] ACT_STIRRER     = 4'd8;
  localparam logic [3:0] ACT_COOLER      = 4'd9;

  // Drive bit positions
  localparam int DRV_HEAT = 0;
  localparam int DRV_STIR = 1;
  localparam int DRV_COOL = 2;

  // Reset values (tenths of a degree, seconds)
  localparam logic [10:0] MAX_SAFE_RESET = 11'd900;
  localparam logic signed [11:0] TARGET_RESET = 12'sd720;
  localparam logic signed [11:0] COOL_RESET = 12'sd350;
  localparam logic [15:0] HOLD_REQ_RESET = 16'd15;

  // Hysteresis band below target (1.0 degree) and hold margin (0.5 degree)
  localparam logic signed [12:0] HYST_BAND = 13'sd10;
  localparam logic signed [12:0] HOLD_MARGIN = 13'sd5;

  // Milliseconds per second
  localparam logic [16:0] MS_PER_S = 17'd1000;

  // One input word
  typedef struct packed {
    logic [3:0]         action;
    logic signed [11:0] temperature;
    logic               sensor_fault;
    logic [15:0]        elapsed_ms;
    logic signed [11:0] target_temp;
    logic [15:0]        hold_seconds;
    logic signed [11:0] cool_temp;
    logic               switch_on;
  } item_t;

  // One result word
  typedef struct packed {
    mode_t       mode;
    pstate_t     process_state;
    fault_t      fault;
    logic        heater;
    logic        stirrer;
    logic        cooler;
    cmd_status_t command_status;
    logic [15:0] hold_elapsed;
  } result_t;

endpackage

>>> hdl/heat_hold_cool_sequencer.sv
// Heat / hold / cool sequencer top level: input register, sequencer core,
// result register and the over-temperature threshold register.
// Depends on hhcs_pkg and hhcs_core.
//
// Usage:
//   s_* carries one word per input event: a tick (action 0) with a sample,
//   sensor fault flag and elapsed milliseconds, or an operator command.
//   m_* returns exactly one result word per input word, in order.
//   cfg_* writes max_safe_temp; write it only while no word is in flight.
// Data path and throughput:
//   A word taken on s_* passes through the input register, then the result
//   register written by the single-pass core logic, before it appears on m_*.
//   One word per cycle is sustained while m_tready is high; the core is a
//   single pass because every word updates the state the next one reads.
// Reset (rst, synchronous): mode and process state go idle, fault clears,
//   drives go off, setpoints return to 72.0 / 35.0 degrees and 15 s, the
//   threshold returns to 90.0 degrees, and both registers are emptied.
// Stall: while m_tready is low the result holds; one more word can wait in
//   the input register, after which s_tready drops.
`timescale 1ns / 1ps
module heat_hold_cool_sequencer
  import hhcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input words
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata, low bit up: temperature[11:0], sensor_fault[12], elapsed_ms[28:13],
  // target_temp[40:29], hold_seconds[56:41], cool_temp[68:57], switch_on[69]
  input  logic [71:0] s_tdata,
  // tuser: action[3:0]
  input  logic [3:0]  s_tuser,
  // Result words
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata, low bit up: mode[1:0], process_state[4:2], fault[6:5], heater[7],
  // stirrer[8], cooler[9], hold_elapsed[25:10]
  output logic [31:0] m_tdata,
  // tuser: command_status[1:0]
  output logic [1:0]  m_tuser,
  // Threshold register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  logic        in_valid;
  item_t       in_item;
  logic        advance;
  logic        out_valid;
  result_t     out_res;
  result_t     core_res;
  logic [10:0] max_safe_temp;

  // Handshake: the input register drains whenever the result register is free.
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_safe_temp <= MAX_SAFE_RESET;
    end else if (cfg_valid) begin
      max_safe_temp <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.action       <= s_tuser;
      in_item.temperature  <= s_tdata[11:0];
      in_item.sensor_fault <= s_tdata[12];
      in_item.elapsed_ms   <= s_tdata[28:13];
      in_item.target_temp  <= s_tdata[40:29];
      in_item.hold_seconds <= s_tdata[56:41];
      in_item.cool_temp    <= s_tdata[68:57];
      in_item.switch_on    <= s_tdata[69];
    end
  end

  hhcs_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .item          (in_item),
    .max_safe_temp (max_safe_temp),
    .result        (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  // Pack the result word
  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_res.hold_elapsed, out_res.cooler, out_res.stirrer,
                     out_res.heater, out_res.fault, out_res.process_state, out_res.mode};
  assign m_tuser  = out_res.command_status;

endmodule

>>> hdl/hhcs_hold_acc.sv
// Hold-time accumulator: adds the tick's milliseconds to the remainder and
// carries whole seconds into the saturating hold count. Uses hhcs_pkg.
`timescale 1ns / 1ps
module hhcs_hold_acc
  import hhcs_pkg::*;
(
  input  logic [15:0] cnt_base,
  input  logic [9:0]  rem_base,
  input  logic [15:0] elapsed_ms,
  output logic [15:0] cnt,
  output logic [9:0]  rem
);

  logic [16:0] sum;
  logic [27:0] scaled;
  logic [6:0]  q_est;
  logic [16:0] q_thou;
  logic [16:0] r_est;
  logic        carry_one;
  logic [6:0]  q;
  logic [16:0] r;
  logic [16:0] cnt_sum;

  // Sum stays at most 999 + 65535, so the quotient by 1000 is at most 66.
  assign sum = {7'd0, rem_base} + {1'b0, elapsed_ms};

  // Quotient estimate: sum * 1048 / 2^20 is the true quotient or one less.
  assign scaled = ({11'd0, sum} << 10) + ({11'd0, sum} << 4) + ({11'd0, sum} << 3);
  assign q_est  = scaled[26:20];

  // q * 1000 as shifts: 1024q - 16q - 8q.
  assign q_thou = ({10'd0, q_est} << 10) - ({10'd0, q_est} << 4) - ({10'd0, q_est} << 3);
  assign r_est  = sum - q_thou;

  // One correction step.
  assign carry_one = (r_est >= MS_PER_S);
  assign q = carry_one ? q_est + 7'd1 : q_est;
  assign r = carry_one ? r_est - MS_PER_S : r_est;

  // Saturating count.
  assign cnt_sum = {1'b0, cnt_base} + {10'd0, q};
  assign cnt = cnt_sum[16] ? 16'hFFFF : cnt_sum[15:0];
  assign rem = r[9:0];

endmodule

>>> hdl/hhcs_core.sv
// Sequencer state registers and the single-pass next-state logic for one
// word. Uses hhcs_pkg and instantiates hhcs_hold_acc.
`timescale 1ns / 1ps
module hhcs_core
  import hhcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  item_t       item,
  input  logic [10:0] max_safe_temp,
  output result_t     result
);

  // State registers
  mode_t              mode_q;
  pstate_t            ps_q;
  fault_t             fault_q;
  logic signed [11:0] target_q;
  logic signed [11:0] cool_q;
  logic [15:0]        hold_req_q;
  logic [15:0]        hold_cnt_q;
  logic [9:0]         ms_rem_q;
  logic [2:0]         drive_q;

  // Next values
  mode_t              mode_next;
  pstate_t            ps_next;
  fault_t             fault_next;
  logic signed [11:0] target_next;
  logic signed [11:0] cool_next;
  logic [15:0]        hold_req_next;
  logic [15:0]        hold_cnt_next;
  logic [9:0]         ms_rem_next;
  logic [2:0]         drive_next;
  cmd_status_t        status;

  // Comparisons
  logic signed [12:0] t13;
  logic signed [12:0] tgt13;
  logic signed [12:0] cool13;
  logic signed [12:0] safe13;
  logic               overt;
  logic               t_ge_tgt;
  logic               t_le_band;
  logic               t_ge_margin;
  logic               t_le_cool;
  logic               hold_met;
  logic               safety_trip;
  logic               enter_hold;

  // Accumulator hookup
  logic [15:0] acc_cnt_base;
  logic [9:0]  acc_rem_base;
  logic [15:0] acc_cnt;
  logic [9:0]  acc_rem;

  assign t13    = {item.temperature[11], item.temperature};
  assign tgt13  = {target_q[11], target_q};
  assign cool13 = {cool_q[11], cool_q};
  assign safe13 = $signed({2'b00, max_safe_temp});

  assign overt       = (t13 >= safe13);
  assign t_ge_tgt    = (t13 >= tgt13);
  assign t_le_band   = (t13 <= tgt13 - HYST_BAND);
  assign t_ge_margin = (t13 >= tgt13 - HOLD_MARGIN);
  assign t_le_cool   = (t13 <= cool13);
  assign hold_met    = (hold_cnt_q >= hold_req_q);

  // A tick leaves heating for holding when no safety check trips and the
  // sample has reached the target.
  assign safety_trip = (item.sensor_fault || overt) && (mode_q != MD_EMERG);
  assign enter_hold  = (item.action == ACT_TICK) && (mode_q == MD_AUTO) &&
                       (ps_q == PS_HEAT) && !safety_trip && t_ge_tgt;

  // A tick that enters holding counts from a cleared count and remainder.
  assign acc_cnt_base = enter_hold ? 16'd0 : hold_cnt_q;
  assign acc_rem_base = enter_hold ? 10'd0 : ms_rem_q;

  hhcs_hold_acc u_hold_acc (
    .cnt_base   (acc_cnt_base),
    .rem_base   (acc_rem_base),
    .elapsed_ms (item.elapsed_ms),
    .cnt        (acc_cnt),
    .rem        (acc_rem)
  );

  // Next-state logic for one word
  always_comb begin
    mode_next     = mode_q;
    ps_next       = ps_q;
    fault_next    = fault_q;
    target_next   = target_q;
    cool_next     = cool_q;
    hold_req_next = hold_req_q;
    hold_cnt_next = hold_cnt_q;
    ms_rem_next   = ms_rem_q;
    drive_next    = drive_q;
    status        = CST_EXECUTED;

    case (item.action)
      ACT_TICK: begin
        status = CST_NONE;
        // Safety checks first; over temperature wins over a sensor fault.
        if (item.sensor_fault && mode_q != MD_EMERG) begin
          fault_next = FLT_SENSOR;
          ps_next    = PS_FAULT;
          drive_next = 3'b000;
        end
        if (overt && mode_q != MD_EMERG) begin
          fault_next = FLT_OVER;
          ps_next    = PS_FAULT;
          drive_next = 3'b000;
        end
        // Auto sequence
        if (mode_q == MD_AUTO) begin
          case (ps_next)
            PS_HEAT: begin
              drive_next[DRV_STIR] = 1'b1;
              drive_next[DRV_COOL] = 1'b0;
              if (t_ge_tgt) begin
                drive_next[DRV_HEAT] = 1'b0;
                ps_next    = PS_HOLD;
              end else if (t_le_band) begin
                drive_next[DRV_HEAT] = 1'b1;
              end
            end
            PS_HOLD: begin
              drive_next[DRV_STIR] = 1'b1;
              drive_next[DRV_COOL] = 1'b0;
              drive_next[DRV_HEAT] = !t_ge_tgt;
              if (hold_met) begin
                ps_next = PS_COOL;
              end
            end
            PS_COOL: begin
              drive_next = 3'b110;
              if (t_le_cool) begin
                ps_next    = PS_DONE;
                drive_next = 3'b000;
              end
            end
            PS_DONE: begin
              drive_next = 3'b000;
            end
            default: begin
            end
          endcase
        end
        // Hold counting, or fall back to heating when the sample drops.
        if (ps_next == PS_HOLD) begin
          if (t_ge_margin) begin
            hold_cnt_next = acc_cnt;
            ms_rem_next   = acc_rem;
          end else begin
            mode_next = MD_AUTO;
            ps_next   = PS_HEAT;
            if (enter_hold) begin
              hold_cnt_next = 16'd0;
              ms_rem_next   = 10'd0;
            end
          end
        end else if (enter_hold) begin
          hold_cnt_next = 16'd0;
          ms_rem_next   = 10'd0;
        end
      end
      ACT_AUTO_START: begin
        if (mode_q == MD_EMERG || ps_q == PS_FAULT || item.sensor_fault) begin
          status = CST_REJECTED;
        end else begin
          target_next   = item.target_temp;
          hold_req_next = item.hold_seconds;
          cool_next     = item.cool_temp;
          mode_next     = MD_AUTO;
          ps_next       = PS_HEAT;
        end
      end
      ACT_STOP: begin
        mode_next  = MD_IDLE;
        ps_next    = PS_IDLE;
        drive_next = 3'b000;
      end
      ACT_MANUAL: begin
        if (mode_q == MD_EMERG || ps_q == PS_FAULT) begin
          status = CST_REJECTED;
        end else begin
          mode_next = MD_MANUAL;
          ps_next   = PS_MANUAL;
        end
      end
      ACT_EMERG_STOP: begin
        mode_next  = MD_EMERG;
        ps_next    = PS_EMERG;
        fault_next = FLT_EMERG;
        drive_next = 3'b000;
      end
      ACT_CLEAR_EMERG: begin
        if (mode_q == MD_EMERG) begin
          fault_next = FLT_NONE;
          mode_next  = MD_IDLE;
          ps_next    = PS_IDLE;
          drive_next = 3'b000;
        end else begin
          status = CST_REJECTED;
        end
      end
      ACT_RESET: begin
        if (ps_q == PS_FAULT && (item.sensor_fault || overt)) begin
          status = CST_REJECTED;
        end else begin
          if (ps_q == PS_FAULT) begin
            fault_next = FLT_NONE;
          end
          mode_next  = MD_IDLE;
          ps_next    = PS_IDLE;
          drive_next = 3'b000;
        end
      end
      ACT_HEATER: begin
        if (mode_q != MD_MANUAL || (item.switch_on && (overt || item.sensor_fault))) begin
          status = CST_REJECTED;
        end else begin
          drive_next[DRV_HEAT] = item.switch_on;
        end
      end
      ACT_STIRRER: begin
        if (mode_q != MD_MANUAL) begin
          status = CST_REJECTED;
        end else begin
          drive_next[DRV_STIR] = item.switch_on;
        end
      end
      ACT_COOLER: begin
        if (mode_q != MD_MANUAL) begin
          status = CST_REJECTED;
        end else begin
          drive_next[DRV_COOL] = item.switch_on;
        end
      end
      default: begin
        status = CST_REJECTED;
      end
    endcase
  end

  // Result as seen after the update
  always_comb begin
    result.mode           = mode_next;
    result.process_state  = ps_next;
    result.fault          = fault_next;
    result.heater         = drive_next[DRV_HEAT];
    result.stirrer        = drive_next[DRV_STIR];
    result.cooler         = drive_next[DRV_COOL];
    result.command_status = status;
    result.hold_elapsed   = hold_cnt_next;
  end

  // State registers advance once per processed word
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q     <= MD_IDLE;
      ps_q       <= PS_IDLE;
      fault_q    <= FLT_NONE;
      target_q   <= TARGET_RESET;
      cool_q     <= COOL_RESET;
      hold_req_q <= HOLD_REQ_RESET;
      hold_cnt_q <= 16'd0;
      ms_rem_q   <= 10'd0;
      drive_q    <= 3'b000;
    end else if (step) begin
      mode_q     <= mode_next;
      ps_q       <= ps_next;
      fault_q    <= fault_next;
      target_q   <= target_next;
      cool_q     <= cool_next;
      hold_req_q <= hold_req_next;
      hold_cnt_q <= hold_cnt_next;
      ms_rem_q   <= ms_rem_next;
      drive_q    <= drive_next;
    end
  end

endmodule

>>> hdl/hhcs_checker.sv
// Port-level checker for the heat / hold / cool sequencer, bound to the top.
// Depends on hhcs_pkg for state, mode and fault codes.
`timescale 1ns / 1ps
module hhcs_checker
  import hhcs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  logic [1:0] r_mode;
  logic [2:0] r_state;
  logic [1:0] r_fault;
  logic [2:0] r_drives;

  assign r_mode   = m_tdata[1:0];
  assign r_state  = m_tdata[4:2];
  assign r_fault  = m_tdata[6:5];
  assign r_drives = m_tdata[9:7];

  // No result word is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // The emergency state comes with emergency mode, emergency fault and no drive.
  a_emerg_consistent: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && r_state == PS_EMERG) |->
      (r_mode == MD_EMERG && r_fault == FLT_EMERG && r_drives == 3'b000))
    else $error("inconsistent emergency result");

  // Idle and complete states never drive anything.
  a_rest_drives_off: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (r_state == PS_IDLE || r_state == PS_DONE)) |-> (r_drives == 3'b000))
    else $error("drive on while idle or complete");

endmodule

bind heat_hold_cool_sequencer hhcs_checker u_hhcs_checker (.*);
